### src/stream_find_replace_unit_macros.svh
// Assertion helpers shared by the stream find-and-replace block.
`ifndef STREAM_FIND_REPLACE_UNIT_MACROS_SVH
`define STREAM_FIND_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd3;

    // Job queue between the classifier and the serializer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

### src/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int JOB_BYTES       = 8,
    parameter int CNT_W           = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]       s_tdata,
    input  logic                             s_tlast,
    output logic                             job_valid,
    input  logic                             job_ready,
    output logic [JOB_BYTES*sfr_pkg::BYTE_W-1:0] job_bytes,
    output logic [CNT_W-1:0]                 job_cnt
);

    localparam int WIN_W = MAX_PATTERN * sfr_pkg::BYTE_W;
    localparam int JOB_W = JOB_BYTES * sfr_pkg::BYTE_W;

    logic [sfr_pkg::LEN_W-1:0]      pat_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]      rep_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] rep_bytes_reg;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic [CNT_W-1:0] wcnt_reg;
    logic [CNT_W-1:0] wcnt_next;

    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] eff_rep;
    logic [CNT_W-1:0] wpos;
    logic [CNT_W-1:0] wcnt_app;
    logic [WIN_W-1:0] win_app;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic             match;
    logic             ripe;
    logic             take_rep;
    logic [CNT_W-1:0] shift_by;
    logic [WIN_W-1:0] win_shift;
    logic             accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= sfr_pkg::LEN_W'(1);
            pat_bytes_reg <= '0;
            rep_len_reg   <= '0;
            rep_bytes_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfr_pkg::REG_PATTERN_LENGTH: begin
                    pat_len_reg <= cfg_wdata[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::REG_PATTERN_BYTES: begin
                    pat_bytes_reg <= cfg_wdata;
                end
                sfr_pkg::REG_REPLACEMENT_LENGTH: begin
                    rep_len_reg <= cfg_wdata[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::REG_REPLACEMENT_BYTES: begin
                    rep_bytes_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // A zero pattern length acts as one; both lengths clamp to their maxima.
    always_comb begin
        if (pat_len_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (pat_len_reg > sfr_pkg::LEN_W'(MAX_PATTERN)) begin
            eff_len = CNT_W'(MAX_PATTERN);
        end else begin
            eff_len = CNT_W'(pat_len_reg);
        end
        if (rep_len_reg > sfr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
            eff_rep = CNT_W'(MAX_REPLACEMENT);
        end else begin
            eff_rep = CNT_W'(rep_len_reg);
        end
    end

    // A full window takes the new byte in its last slot.
    assign wpos     = (wcnt_reg >= CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN - 1) : wcnt_reg;
    assign wcnt_app = wpos + CNT_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) == wpos) begin
                win_app[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = s_tdata;
            end else begin
                win_app[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] =
                    win_reg[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            end
            byte_ok[i] = (CNT_W'(i) >= eff_len) ||
                (win_app[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] ==
                 pat_bytes_reg[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]);
        end
    end

    assign match    = &byte_ok;
    assign ripe     = (wcnt_app >= eff_len);
    // An end mark on an oversized window flushes it without comparing.
    assign take_rep = ripe && match && !(s_tlast && (wcnt_app > eff_len));
    assign shift_by = take_rep ? eff_len : CNT_W'(1);
    assign win_shift = win_app >> {shift_by, 3'b000};

    always_comb begin
        job_bytes = JOB_W'(win_app);
        job_cnt   = '0;
        win_next  = win_app;
        wcnt_next = wcnt_app;
        if (take_rep) begin
            job_bytes = JOB_W'(rep_bytes_reg[MAX_REPLACEMENT*sfr_pkg::BYTE_W-1:0]);
            job_cnt   = eff_rep;
            win_next  = win_shift;
            wcnt_next = s_tlast ? '0 : (wcnt_app - eff_len);
        end else if (s_tlast) begin
            job_cnt   = wcnt_app;
            wcnt_next = '0;
        end else if (ripe) begin
            job_cnt   = CNT_W'(1);
            win_next  = win_shift;
            wcnt_next = wcnt_app - CNT_W'(1);
        end
    end

    assign s_tready  = job_ready;
    assign accept    = s_tvalid && job_ready;
    assign job_valid = s_tvalid && (job_cnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
        end else if (accept) begin
            wcnt_reg <= wcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

### src/sfr_queue.sv
`timescale 1ns / 1ps
`include "stream_find_replace_unit_macros.svh"

module sfr_queue #(
    parameter int JOB_W = 64,
    parameter int CNT_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [JOB_W-1:0] in_bytes,
    input  logic [CNT_W-1:0] in_cnt,
    output logic             out_valid,
    output logic [JOB_W-1:0] out_bytes,
    output logic [CNT_W-1:0] out_cnt,
    input  logic             out_pop
);

    logic [JOB_W-1:0] bytes_reg [sfr_pkg::QUEUE_DEPTH];
    logic [CNT_W-1:0] cnt_reg   [sfr_pkg::QUEUE_DEPTH];
    logic [sfr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sfr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sfr_pkg::QCNT_W-1:0] fill_reg;
    logic [sfr_pkg::QCNT_W-1:0] fill_next;
    logic push;
    logic pop;

    assign in_ready  = (fill_reg != sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_bytes = bytes_reg[rd_ptr_reg];
    assign out_cnt   = cnt_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + sfr_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - sfr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + sfr_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + sfr_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            bytes_reg[wr_ptr_reg] <= in_bytes;
            cnt_reg[wr_ptr_reg]   <= in_cnt;
        end
    end

    `SFR_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH), "job queue fill exceeds depth")
    `SFR_ASSERT_NOW(a_ptr_agree, aclk, aresetn, fill_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with unequal pointers")
    `SFR_ASSERT_NEXT(a_fill_up, aclk, aresetn, push && !pop, fill_reg == $past(fill_reg) + sfr_pkg::QCNT_W'(1), "push did not raise fill")

endmodule

### src/sfr_back.sv
`timescale 1ns / 1ps
`include "stream_find_replace_unit_macros.svh"

module sfr_back #(
    parameter int JOB_BYTES = 8,
    parameter int CNT_W     = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 head_valid,
    input  logic [JOB_BYTES*sfr_pkg::BYTE_W-1:0] head_bytes,
    input  logic [CNT_W-1:0]                     head_cnt,
    output logic                                 head_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]           m_tdata,
    output logic                                 m_tlast
);

    localparam int IDX_W = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             fire;
    logic             last;

    assign last     = (CNT_W'(idx_reg) == (head_cnt - CNT_W'(1)));
    assign fire     = m_tvalid && m_tready;
    assign m_tvalid = head_valid;
    assign m_tdata  = head_bytes[{idx_reg, 3'b000} +: sfr_pkg::BYTE_W];
    assign m_tlast  = last;
    assign head_pop = fire && last;

    always_comb begin
        idx_next = idx_reg;
        if (fire) begin
            idx_next = last ? '0 : (idx_reg + IDX_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    `SFR_ASSERT_NOW(a_no_empty_job, aclk, aresetn, head_valid, head_cnt != '0, "queued job carries no bytes")
    `SFR_ASSERT_NOW(a_idx_in_job, aclk, aresetn, head_valid, CNT_W'(idx_reg) < head_cnt, "byte index beyond job length")
    `SFR_ASSERT_NEXT(a_idx_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(idx_reg), "byte index moved while stalled")

endmodule

### src/stream_find_replace_unit.sv
`timescale 1ns / 1ps

// Streaming find-and-replace on a byte stream. Each input item carries one
// text byte (s_tdata) and an end-of-text flag (s_tlast); every leftmost,
// non-overlapping occurrence of the configured pattern is replaced by the
// configured replacement, and inserted text is never searched again. Each
// output item is one byte, and m_tlast marks the final byte caused by an
// input item; an input item may cause no output at all. The block accepts
// one item per cycle while the job queue is not full, and the first byte
// it causes appears the cycle after acceptance if the queue was empty. An
// item causing several bytes holds the output until all leave; a four-entry
// job queue between the classifier and the output serializer absorbs that,
// and s_tready falls only while the queue is full. Configuration registers
// (pattern length, pattern bytes, replacement length, replacement bytes, by
// index 0 to 3) are written through cfg_wr_en/cfg_index/cfg_wdata and must
// change only while the block is idle. Reset is synchronous and active low.

module stream_find_replace_unit #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // end_of_text
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast    // last_of_run
);

    // One job holds every byte an input item can cause.
    localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CNT_W     = $clog2(JOB_BYTES + 1);
    localparam int JOB_W     = JOB_BYTES * sfr_pkg::BYTE_W;

    logic             job_valid;
    logic             job_ready;
    logic [JOB_W-1:0] job_bytes;
    logic [CNT_W-1:0] job_cnt;
    logic             head_valid;
    logic [JOB_W-1:0] head_bytes;
    logic [CNT_W-1:0] head_cnt;
    logic             head_pop;

    // Front: holds the match window, compares it to the pattern and turns
    // each accepted item into one job of up to JOB_BYTES output bytes.
    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .JOB_BYTES       (JOB_BYTES),
        .CNT_W           (CNT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_bytes (job_bytes),
        .job_cnt   (job_cnt)
    );

    // Jobs that produce no bytes never enter the queue.
    sfr_queue #(
        .JOB_W (JOB_W),
        .CNT_W (CNT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_bytes  (job_bytes),
        .in_cnt    (job_cnt),
        .out_valid (head_valid),
        .out_bytes (head_bytes),
        .out_cnt   (head_cnt),
        .out_pop   (head_pop)
    );

    // Back: sends the head job one byte per item, last byte tagged.
    sfr_back #(
        .JOB_BYTES (JOB_BYTES),
        .CNT_W     (CNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_bytes (head_bytes),
        .head_cnt   (head_cnt),
        .head_pop   (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the stream find-and-replace unit. Text bytes go in
// on the s_ stream, rewritten bytes come out on the m_ stream, and one
// process watches both sides. It predicts the rewritten text for every
// accepted input item and checks every accepted output item against the
// oldest prediction.

module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int SEGMENT_ITEMS = 34;

    // One predicted output item: the byte and its end-of-run flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'h00;   // [7:0] data_byte
    logic                           s_tlast   = 1'b0;    // end_of_text
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;             // [7:0] out_byte
    logic                           m_tlast;             // last_of_run

    // Chance, in percent, that the sender idles before an item and that the
    // receiver stalls in a given cycle.
    int idle_pct  = 0;
    int stall_pct = 0;

    int mismatch_count = 0;

    // Copy of the configuration as the predictor sees it (raw register values).
    logic [3:0]  plen_shadow;
    logic [63:0] pattern_shadow;
    logic [3:0]  rlen_shadow;
    logic [63:0] replacement_shadow;

    // Predictor copy of the pending window and the expected output text.
    logic [7:0]  window [8];
    int unsigned window_fill;
    text_beat_t  rewritten_text [$];

    // Stimulus-side view of the pattern, used to build matching text.
    int          stim_plen    = 1;
    logic [63:0] stim_pattern = '0;

    stream_find_replace_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Removes the oldest k bytes from the predicted window.
    function automatic void drop_window(input int unsigned k);
        if (k >= window_fill) begin
            window_fill = 0;
        end else begin
            for (int unsigned i = 0; i < window_fill - k; i++) window[i] = window[i + k];
            window_fill -= k;
        end
    endfunction

    // Predicts the output bytes that one accepted text byte causes and appends
    // them to the expected text, with the last one flagged.
    function automatic void rewrite_byte(input logic [7:0] b, input logic eot);
        int unsigned len;
        int unsigned rlen;
        bit          hit;
        logic [7:0]  run [$];
        text_beat_t  beat;
        len  = plen_shadow;
        if (len < 1) len = 1;
        if (len > 8) len = 8;
        rlen = (rlen_shadow > 8) ? 8 : rlen_shadow;
        if (window_fill >= 8) window_fill = 7;
        window[window_fill] = b;
        window_fill++;
        // An end mark on a window wider than the pattern flushes it unchanged;
        // otherwise the oldest len bytes are compared first.
        if (!(eot && window_fill > len) && window_fill >= len) begin
            hit = 1'b1;
            for (int unsigned i = 0; i < len; i++)
                if (window[i] != pattern_shadow[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                for (int unsigned i = 0; i < rlen; i++)
                    run.push_back(replacement_shadow[8*i +: 8]);
                drop_window(len);
            end else begin
                run.push_back(window[0]);
                drop_window(1);
            end
        end
        if (eot) begin
            for (int unsigned i = 0; i < window_fill; i++) run.push_back(window[i]);
            window_fill = 0;
        end
        for (int i = 0; i < run.size(); i++) begin
            beat.data = run[i];
            beat.last = (i == run.size() - 1);
            rewritten_text.push_back(beat);
        end
    endfunction

    // Watches both streams and the configuration port. Output items are checked
    // before the input of the same edge is predicted; an item's first result
    // can only appear on a later edge.
    always @(posedge aclk) begin : watch_streams
        text_beat_t want;
        if (!aresetn) begin
            plen_shadow        = 4'd1;
            pattern_shadow     = '0;
            rlen_shadow        = 4'd0;
            replacement_shadow = '0;
            window_fill        = 0;
            rewritten_text.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (rewritten_text.size() == 0) begin
                    report_mismatch("output byte with nothing expected", 0, m_tdata);
                end else begin
                    want = rewritten_text.pop_front();
                    if (m_tdata !== want.data) report_mismatch("out_byte", want.data, m_tdata);
                    if (m_tlast !== want.last) report_mismatch("last_of_run", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) rewrite_byte(s_tdata, s_tlast);
            if (cfg_wr_en) begin
                case (cfg_index)
                    sfr_pkg::REG_PATTERN_LENGTH:     plen_shadow        = cfg_wdata[3:0];
                    sfr_pkg::REG_PATTERN_BYTES:      pattern_shadow     = cfg_wdata;
                    sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_shadow        = cfg_wdata[3:0];
                    sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_shadow = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Receiver backpressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one text byte and returns at the edge where it is accepted. Valid
    // stays high on return so back-to-back items need no gap.
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lets every expected byte come out, then gives the block time to finish
    // items that cause no output.
    task automatic drain_text();
        int waited;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (rewritten_text.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Writes all four registers. Called after drain_text; the window may still hold pending bytes.
    task automatic configure(input logic [3:0] plen, input logic [63:0] pat,
                             input logic [3:0] rlen, input logic [63:0] rep);
        write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
        write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
        write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'(rlen));
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
        cfg_wr_en    <= 1'b0;
        stim_plen    = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
        stim_pattern = pat;
    endtask

    // Out of reset the pattern is a single zero byte and the replacement is
    // empty, so zero bytes vanish and everything else passes through.
    task automatic test_default_config();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h00, 1'b1);
        drain_text();
    endtask

    // A three-byte pattern expanded to a full eight-byte replacement, then a
    // partial match cut off by an end mark.
    task automatic test_match_and_expansion();
        configure(4'd3, 64'h0000_0000_0063_6261, 4'd8, 64'h4847_4645_4443_4241);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h63, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h00, 1'b1);
        drain_text();
    endtask

    // Length zero acts as one, and lengths above eight saturate. The seven
    // bytes left pending at the end are picked up by the shrink test.
    task automatic test_length_saturation();
        configure(4'd0, 64'h0000_0000_0000_00FF, 4'd12, 64'h0123_4567_89AB_CDEF);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h01, 1'b1);
        drain_text();
        configure(4'd15, '1, 4'd0, 64'h0);
        repeat (7) send_text_byte(8'hFF, 1'b0);
        drain_text();
    endtask

    // The pattern shrinks while seven bytes are pending: the next byte matches
    // on the oldest two, and the end mark then flushes an oversized window.
    task automatic test_pattern_shrink();
        configure(4'd2, 64'h0000_0000_0000_FFFF, 4'd1, 64'h0000_0000_0000_00AA);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h00, 1'b1);
        drain_text();
    endtask

    // Random text built mostly from the pattern's own bytes, with whole and
    // broken copies of the pattern, over several settings and idling phases.
    task automatic test_random_text();
        int          phase_idle  [4] = '{0, 71, 0, 21};
        int          phase_stall [4] = '{0, 0, 71, 21};
        int          sent;
        int          pick;
        int          bad_pos;
        logic [7:0]  b;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            for (int seg = 0; seg < 3; seg++) begin
                case ((phase * 3 + seg) % 4)
                    0: begin plen = 4'd1; rlen = 4'd0; end
                    1: begin plen = 4'd8; rlen = 4'd8; end
                    2: begin plen = 4'($urandom_range(1, 4)); rlen = 4'($urandom_range(0, 12)); end
                    default: begin
                        plen = 4'($urandom_range(0, 15));
                        rlen = 4'($urandom_range(0, 15));
                    end
                endcase
                configure(plen, {$urandom, $urandom}, rlen, {$urandom, $urandom});
                sent = 0;
                while (sent < SEGMENT_ITEMS) begin
                    pick = $urandom_range(99);
                    if (pick < 35) begin
                        // Whole pattern, sometimes with one byte spoiled.
                        bad_pos = ($urandom_range(99) < 15) ? $urandom_range(0, stim_plen - 1) : -1;
                        for (int i = 0; i < stim_plen; i++) begin
                            b = (i == bad_pos) ? 8'($urandom) : stim_pattern[8*i +: 8];
                            send_text_byte(b, $urandom_range(11) == 0);
                            sent++;
                        end
                    end else begin
                        if (pick < 80) b = stim_pattern[8*$urandom_range(0, stim_plen - 1) +: 8];
                        else b = 8'($urandom);
                        send_text_byte(b, $urandom_range(11) == 0);
                        sent++;
                    end
                end
                drain_text();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_config();
        test_match_and_expansion();
        test_length_saturation();
        test_pattern_shrink();
        test_random_text();
        drain_text();
        if (rewritten_text.size() != 0)
            report_mismatch("bytes never delivered", 0, rewritten_text.size());
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
